[rtl/assert_macros.svh]
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Check a property at each rising clock edge, also during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/egu_pkg.sv]
`timescale 1ns / 1ps
package egu_pkg;

	typedef enum logic [3:0] {
		ACT_ADD     = 4'd0,
		ACT_SUB     = 4'd1,
		ACT_MUL     = 4'd2,
		ACT_DIV     = 4'd3,
		ACT_SQUARE  = 4'd4,
		ACT_RELU    = 4'd5,
		ACT_SIGMOID = 4'd6,
		ACT_TANH    = 4'd7,
		ACT_SOFTMAX = 4'd8,
		ACT_XENT    = 4'd9,
		ACT_DROPOUT = 4'd10,
		ACT_SGD     = 4'd11
	} action_t;

	localparam logic REG_LR = 1'b0;
	localparam logic REG_DP = 1'b1;

	localparam int LR_W = 17;
	localparam int DP_W = 16;
	localparam logic [LR_W-1:0] LR_RESET = 17'd655;
	localparam logic [DP_W-1:0] DP_RESET = 16'd0;

	localparam int REG_FRAC = 16;
	localparam int DIV_NUM_W = 63;
	localparam int DIV_A_DEN_W = 32;
	localparam int DIV_B_DEN_W = 63;
	localparam int SIDE_DLY = DIV_NUM_W - 2;
	localparam int PIPE_STAGES = DIV_NUM_W + 2;

	typedef struct packed {
		action_t             act;
		logic                second;
		logic signed [31:0]  g;
		logic signed [31:0]  a;
		logic signed [31:0]  ga;
		logic signed [31:0]  gb;
		logic signed [67:0]  rx;
		logic signed [67:0]  ry;
		logic signed [95:0]  rd;
		logic                neg_a;
		logic                neg_b;
	} side_t;

endpackage

[rtl/elementwise_gradient_unit.sv]
`timescale 1ns / 1ps
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Depth is set by the two 63-step restoring divider pipelines.
// Reset clears all valid bits and loads learning_rate = 655, dropout_prob = 0.
module elementwise_gradient_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,  // grad_out, a_value, b_value, grad_a_old, grad_b_old
	input  logic [4:0]   s_tuser,  // action[3:0], has_second
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // grad_a_new, grad_b_new
	output logic [0:0]   m_tuser,  // saturated
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam logic signed [96:0] SAT_MAX = 97'sh7FFF_FFFF;
	localparam logic signed [96:0] SAT_MIN = -SAT_MAX - 97'sd1;

	logic [egu_pkg::LR_W-1:0] lr_q;
	logic [egu_pkg::DP_W-1:0] dp_q;
	logic en;

	assign pready = 1'b1;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= egu_pkg::LR_RESET;
			dp_q <= egu_pkg::DP_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				egu_pkg::REG_LR: lr_q <= pwdata[egu_pkg::LR_W-1:0];
				egu_pkg::REG_DP: dp_q <= pwdata[egu_pkg::DP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			egu_pkg::REG_LR: prdata = 32'(lr_q);
			egu_pkg::REG_DP: prdata = 32'(dp_q);
			default:         prdata = '0;
		endcase
	end

	egu_pkg::side_t side_c;
	logic [egu_pkg::DIV_NUM_W-1:0]   num_a, num_b, quo_a, quo_b;
	logic [egu_pkg::DIV_A_DEN_W-1:0] den_a;
	logic [egu_pkg::DIV_B_DEN_W-1:0] den_b;

	egu_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk        (clk),
		.en         (en),
		.act        (egu_pkg::action_t'(s_tuser[3:0])),
		.second     (s_tuser[4]),
		.grad_out   (s_tdata[31:0]),
		.a_value    (s_tdata[63:32]),
		.b_value    (s_tdata[95:64]),
		.grad_a_old (s_tdata[127:96]),
		.grad_b_old (s_tdata[159:128]),
		.lr         (lr_q),
		.dp         (dp_q),
		.side       (side_c),
		.num_a      (num_a),
		.den_a      (den_a),
		.num_b      (num_b),
		.den_b      (den_b)
	);

	egu_div #(
		.NUM_W(egu_pkg::DIV_NUM_W),
		.DEN_W(egu_pkg::DIV_A_DEN_W)
	) u_div_a (
		.clk (clk),
		.en  (en),
		.num (num_a),
		.den (den_a),
		.quo (quo_a)
	);

	egu_div #(
		.NUM_W(egu_pkg::DIV_NUM_W),
		.DEN_W(egu_pkg::DIV_B_DEN_W)
	) u_div_b (
		.clk (clk),
		.en  (en),
		.num (num_b),
		.den (den_b),
		.quo (quo_b)
	);

	egu_pkg::side_t side_s [egu_pkg::SIDE_DLY];
	logic [egu_pkg::PIPE_STAGES-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_c;
			for (int k = 1; k < egu_pkg::SIDE_DLY; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[egu_pkg::PIPE_STAGES-2:0], s_tvalid};
		end
	end

	egu_pkg::side_t sd;
	logic signed [96:0] qa_w, qb_w, ga_w, gb_w, g_w, na, nb;
	logic sat_c;

	assign sd   = side_s[egu_pkg::SIDE_DLY-1];
	assign qa_w = sd.neg_a ? -$signed({34'b0, quo_a}) : $signed({34'b0, quo_a});
	assign qb_w = sd.neg_b ? -$signed({34'b0, quo_b}) : $signed({34'b0, quo_b});
	assign ga_w = 97'(sd.ga);
	assign gb_w = 97'(sd.gb);
	assign g_w  = 97'(sd.g);

	always_comb begin
		na = ga_w;
		nb = gb_w;
		unique case (sd.act)
			egu_pkg::ACT_ADD: begin
				na = ga_w + g_w;
				if (sd.second) nb = gb_w + g_w;
			end
			egu_pkg::ACT_SUB: begin
				na = ga_w + g_w;
				if (sd.second) nb = gb_w - g_w;
			end
			egu_pkg::ACT_MUL: begin
				na = ga_w + 97'(sd.rx);
				if (sd.second) nb = gb_w + 97'(sd.ry);
			end
			egu_pkg::ACT_DIV: begin
				na = ga_w + qa_w;
				if (sd.second) nb = gb_w - qb_w;
			end
			egu_pkg::ACT_SQUARE: na = ga_w + 97'(sd.rx);
			egu_pkg::ACT_RELU: if (sd.a > 32'sd0) na = ga_w + g_w;
			egu_pkg::ACT_SIGMOID, egu_pkg::ACT_SOFTMAX, egu_pkg::ACT_TANH:
				na = ga_w + 97'(sd.rd);
			egu_pkg::ACT_XENT: if (sd.second) na = ga_w + 97'(sd.rx);
			egu_pkg::ACT_DROPOUT: if (sd.a != 32'sd0) na = ga_w + qa_w;
			egu_pkg::ACT_SGD: na = 97'(sd.a) - 97'(sd.rx);
			default: begin
			end
		endcase
	end

	logic [31:0] na_sat, nb_sat;

	always_comb begin
		sat_c  = 1'b0;
		na_sat = na[31:0];
		nb_sat = nb[31:0];
		if (na > SAT_MAX) begin
			na_sat = SAT_MAX[31:0];
			sat_c  = 1'b1;
		end else if (na < SAT_MIN) begin
			na_sat = SAT_MIN[31:0];
			sat_c  = 1'b1;
		end
		if (nb > SAT_MAX) begin
			nb_sat = SAT_MAX[31:0];
			sat_c  = 1'b1;
		end else if (nb < SAT_MIN) begin
			nb_sat = SAT_MIN[31:0];
			sat_c  = 1'b1;
		end
	end

	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic [0:0]  m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= vld_q[egu_pkg::PIPE_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= {nb_sat, na_sat};
			m_tuser_q <= sat_c;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[rtl/egu_div.sv]
`timescale 1ns / 1ps
module egu_div #(
	parameter int NUM_W = 63,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [NUM_W-1];
	logic [DEN_W-1:0] den_s [NUM_W-1];
	logic [NUM_W-1:0] nq_s  [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W-1:0] r_i;
		logic [DEN_W-1:0] d_i;
		logic [NUM_W-1:0] n_i;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign r_i = '0;
			assign d_i = den;
			assign n_i = num;
		end else begin : g_next
			assign r_i = rem_s[k-1];
			assign d_i = den_s[k-1];
			assign n_i = nq_s[k-1];
		end

		assign trial = {r_i, n_i[NUM_W-1]};
		assign ge    = trial >= {1'b0, d_i};
		assign diff  = trial - {1'b0, d_i};

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[k] <= {n_i[NUM_W-2:0], ge};
			end
		end

		if (k < NUM_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
					den_s[k] <= d_i;
				end
			end
		end
	end

	assign quo = nq_s[NUM_W-1];

endmodule

[rtl/egu_front.sv]
`timescale 1ns / 1ps
module egu_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             en,
	input  egu_pkg::action_t                 act,
	input  logic                             second,
	input  logic signed [31:0]               grad_out,
	input  logic signed [31:0]               a_value,
	input  logic signed [31:0]               b_value,
	input  logic signed [31:0]               grad_a_old,
	input  logic signed [31:0]               grad_b_old,
	input  logic [egu_pkg::LR_W-1:0]         lr,
	input  logic [egu_pkg::DP_W-1:0]         dp,
	output egu_pkg::side_t                   side,
	output logic [egu_pkg::DIV_NUM_W-1:0]    num_a,
	output logic [egu_pkg::DIV_A_DEN_W-1:0]  den_a,
	output logic [egu_pkg::DIV_NUM_W-1:0]    num_b,
	output logic [egu_pkg::DIV_B_DEN_W-1:0]  den_b
);

	localparam logic signed [33:0] ONE34   = 34'sh1 << FRAC_BITS;
	localparam logic signed [67:0] ONE68   = 68'sh1 << FRAC_BITS;
	localparam logic signed [67:0] HALF_F  = 68'sh1 << (FRAC_BITS - 1);
	localparam logic signed [67:0] HALF_F1 = 68'sh1 << (FRAC_BITS - 2);
	localparam logic signed [67:0] HALF_R  = 68'sh1 << (egu_pkg::REG_FRAC - 1);
	localparam logic signed [95:0] HALF_96 = 96'sh1 << (FRAC_BITS - 1);

	// stage 1
	logic signed [33:0] mx_x, mx_y, my_x, my_y;
	logic signed [33:0] g34, a34, b34, ga34;

	egu_pkg::action_t   act_s1;
	logic               second_s1;
	logic signed [31:0] g_s1, a_s1, b_s1, ga_s1, gb_s1;
	logic signed [67:0] px_s1, py_s1;

	assign g34  = 34'(grad_out);
	assign a34  = 34'(a_value);
	assign b34  = 34'(b_value);
	assign ga34 = 34'(grad_a_old);

	always_comb begin
		mx_x = '0;
		mx_y = '0;
		my_x = '0;
		my_y = '0;
		unique case (act)
			egu_pkg::ACT_MUL: begin
				mx_x = g34;
				mx_y = second ? b34 : ONE34;
				my_x = g34;
				my_y = a34;
			end
			egu_pkg::ACT_DIV: begin
				mx_x = g34;
				mx_y = a34;
				my_x = b34;
				my_y = b34;
			end
			egu_pkg::ACT_SQUARE: begin
				mx_x = g34;
				mx_y = a34;
			end
			egu_pkg::ACT_XENT: begin
				mx_x = g34;
				mx_y = a34 - b34;
			end
			egu_pkg::ACT_SIGMOID, egu_pkg::ACT_SOFTMAX: begin
				mx_x = a34;
				mx_y = ONE34 - a34;
			end
			egu_pkg::ACT_TANH: begin
				mx_x = a34;
				mx_y = a34;
			end
			egu_pkg::ACT_SGD: begin
				mx_x = $signed({17'b0, lr});
				mx_y = ga34;
			end
			default: begin
			end
		endcase
	end

	// stage 2
	logic signed [67:0] rxf, rx_c, ryf;
	logic [67:0]        px_mag;
	logic [31:0]        g_mag, b_mag;
	logic               b_nz;
	logic signed [63:0] d_c;
	logic [egu_pkg::DIV_NUM_W-1:0]   num_a_c;
	logic [egu_pkg::DIV_A_DEN_W-1:0] den_a_c;
	logic               neg_a_c;

	egu_pkg::action_t   act_s2;
	logic               second_s2;
	logic signed [31:0] g_s2, a_s2, ga_s2, gb_s2;
	logic signed [67:0] rx_s2, ry_s2;
	logic signed [63:0] d_s2;
	logic               neg_a_s2, neg_b_s2;
	logic [egu_pkg::DIV_NUM_W-1:0]   num_a_s2, num_b_s2;
	logic [egu_pkg::DIV_A_DEN_W-1:0] den_a_s2;
	logic [egu_pkg::DIV_B_DEN_W-1:0] den_b_s2;

	assign rxf    = (px_s1 + HALF_F) >>> FRAC_BITS;
	assign ryf    = (py_s1 + HALF_F) >>> FRAC_BITS;
	assign px_mag = px_s1[67] ? $unsigned(-px_s1) : $unsigned(px_s1);
	assign g_mag  = g_s1[31] ? (~g_s1 + 32'd1) : g_s1;
	assign b_mag  = b_s1[31] ? (~b_s1 + 32'd1) : b_s1;
	assign b_nz   = second_s1 && (b_s1 != 32'sd0);

	always_comb begin
		rx_c    = rxf;
		d_c     = '0;
		num_a_c = '0;
		den_a_c = '0;
		neg_a_c = 1'b0;
		unique case (act_s1)
			egu_pkg::ACT_SQUARE: rx_c = (px_s1 + HALF_F1) >>> (FRAC_BITS - 1);
			egu_pkg::ACT_SGD: rx_c = (px_s1 + HALF_R) >>> egu_pkg::REG_FRAC;
			egu_pkg::ACT_SIGMOID, egu_pkg::ACT_SOFTMAX: d_c = rxf[63:0];
			egu_pkg::ACT_TANH: d_c = 64'(ONE68 - rxf);
			egu_pkg::ACT_DIV: begin
				num_a_c = egu_pkg::DIV_NUM_W'(g_mag) << FRAC_BITS;
				den_a_c = b_nz ? b_mag : (32'd1 << FRAC_BITS);
				neg_a_c = g_s1[31] ^ (b_nz & b_s1[31]);
			end
			egu_pkg::ACT_DROPOUT: begin
				num_a_c = egu_pkg::DIV_NUM_W'(g_mag) << egu_pkg::REG_FRAC;
				den_a_c = 32'(17'h10000 - {1'b0, dp});
				neg_a_c = g_s1[31];
			end
			default: begin
			end
		endcase
	end

	// stage 3
	egu_pkg::action_t   act_s3;
	logic               second_s3;
	logic signed [31:0] g_s3, a_s3, ga_s3, gb_s3;
	logic signed [67:0] rx_s3, ry_s3;
	logic signed [64:0] pp_lo_s3;
	logic signed [63:0] pp_hi_s3;
	logic               neg_a_s3, neg_b_s3;

	// stage 4
	logic signed [95:0] full_c;
	egu_pkg::side_t     side_s4;

	assign full_c = (96'(pp_hi_s3) <<< 32) + 96'(pp_lo_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1    <= act;
			second_s1 <= second;
			g_s1      <= grad_out;
			a_s1      <= a_value;
			b_s1      <= b_value;
			ga_s1     <= grad_a_old;
			gb_s1     <= grad_b_old;
			px_s1     <= mx_x * mx_y;
			py_s1     <= my_x * my_y;

			act_s2    <= act_s1;
			second_s2 <= second_s1;
			g_s2      <= g_s1;
			a_s2      <= a_s1;
			ga_s2     <= ga_s1;
			gb_s2     <= gb_s1;
			rx_s2     <= rx_c;
			ry_s2     <= ryf;
			d_s2      <= d_c;
			neg_a_s2  <= neg_a_c;
			neg_b_s2  <= px_s1[67];
			num_a_s2  <= num_a_c;
			den_a_s2  <= den_a_c;
			num_b_s2  <= px_mag[egu_pkg::DIV_NUM_W-1:0];
			den_b_s2  <= ryf[egu_pkg::DIV_B_DEN_W-1:0] + egu_pkg::DIV_B_DEN_W'(1);

			act_s3    <= act_s2;
			second_s3 <= second_s2;
			g_s3      <= g_s2;
			a_s3      <= a_s2;
			ga_s3     <= ga_s2;
			gb_s3     <= gb_s2;
			rx_s3     <= rx_s2;
			ry_s3     <= ry_s2;
			pp_lo_s3  <= g_s2 * $signed({1'b0, d_s2[31:0]});
			pp_hi_s3  <= g_s2 * $signed(d_s2[63:32]);
			neg_a_s3  <= neg_a_s2;
			neg_b_s3  <= neg_b_s2;

			side_s4.act    <= act_s3;
			side_s4.second <= second_s3;
			side_s4.g      <= g_s3;
			side_s4.a      <= a_s3;
			side_s4.ga     <= ga_s3;
			side_s4.gb     <= gb_s3;
			side_s4.rx     <= rx_s3;
			side_s4.ry     <= ry_s3;
			side_s4.rd     <= (full_c + HALF_96) >>> FRAC_BITS;
			side_s4.neg_a  <= neg_a_s3;
			side_s4.neg_b  <= neg_b_s3;
		end
	end

	assign side  = side_s4;
	assign num_a = num_a_s2;
	assign den_a = den_a_s2;
	assign num_b = num_b_s2;
	assign den_b = den_b_s2;

endmodule

[rtl/egu_chk.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module egu_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [0:0]  m_tuser
);

	`ASSERT_CLK(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	`ASSERT_CLK(a_in_ready, clk, arst_n, s_tready == (!m_tvalid || m_tready), "input ready does not follow output stall")
	`ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind elementwise_gradient_unit egu_chk u_egu_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[tb/elementwise_gradient_unit_tb.sv]
`timescale 1ns / 1ps
module elementwise_gradient_unit_tb;

	localparam logic [3:0] ACT_UNUSED_LO = 4'd12;
	localparam logic [3:0] ACT_UNUSED_HI = 4'd15;
	localparam logic [2:0] ADDR_LR = {egu_pkg::REG_LR, 2'b00};
	localparam logic [2:0] ADDR_DP = {egu_pkg::REG_DP, 2'b00};
	localparam int DRAIN_CYCLES = egu_pkg::PIPE_STAGES + 16;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 175;
	localparam int FRAC_W = 16;

	typedef struct {
		logic [3:0]         act;
		logic               second;
		logic signed [31:0] g;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] ga;
		logic signed [31:0] gb;
	} grad_item_t;

	typedef struct packed {
		logic [31:0] na;
		logic [31:0] nb;
		logic        sat;
	} grad_result_t;

	typedef struct {
		grad_item_t   item;
		logic         fixed;
		grad_result_t want;
	} stim_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [159:0] s_tdata = '0;
	logic [4:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	logic [egu_pkg::LR_W-1:0] lr_shadow = egu_pkg::LR_RESET;
	logic [egu_pkg::DP_W-1:0] dp_shadow = egu_pkg::DP_RESET;
	int snd_idle = 32;
	int rcv_idle = 62;
	int errors = 0;
	grad_result_t pending_grads[$];
	stim_row_t directed_rows[$];

	elementwise_gradient_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic longint round_product(longint x, longint y, int s);
		logic signed [127:0] xw, yw, p, mag, lim;
		xw = x;
		yw = y;
		p = xw * yw;
		mag = (p < 0) ? -p : p;
		lim = 128'sh7fff_ffff_ffff_ffff - (128'sd1 <<< (s - 1));
		if (mag > lim)
			return (p < 0) ? -longint'(lim >>> s) : longint'(lim >>> s);
		return longint'((p + (128'sd1 <<< (s - 1))) >>> s);
	endfunction

	function automatic logic [31:0] clip32(longint v, inout logic flag);
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			return 32'h7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			flag = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic grad_result_t compute_gradients(grad_item_t it);
		longint one, g, a, b, ga, gb, na, nb, d, bd, den;
		logic flag;
		grad_result_t r;
		one = longint'(1) << FRAC_W;
		g = it.g;
		a = it.a;
		b = it.b;
		ga = it.ga;
		gb = it.gb;
		na = ga;
		nb = gb;
		flag = 1'b0;
		case (it.act)
			egu_pkg::ACT_ADD: begin
				na = ga + g;
				if (it.second) nb = gb + g;
			end
			egu_pkg::ACT_SUB: begin
				na = ga + g;
				if (it.second) nb = gb - g;
			end
			egu_pkg::ACT_MUL: begin
				na = ga + round_product(g, it.second ? b : one, FRAC_W);
				if (it.second) nb = gb + round_product(g, a, FRAC_W);
			end
			egu_pkg::ACT_DIV: begin
				bd = (it.second && b != 0) ? b : one;
				na = ga + (g * one) / bd;
				if (it.second) begin
					den = ((b * b + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W) + 1;
					nb = gb - (g * a) / den;
				end
			end
			egu_pkg::ACT_SQUARE: na = ga + round_product(g, a, FRAC_W - 1);
			egu_pkg::ACT_RELU: if (a > 0) na = ga + g;
			egu_pkg::ACT_SIGMOID, egu_pkg::ACT_SOFTMAX: begin
				d = round_product(a, one - a, FRAC_W);
				na = ga + round_product(g, d, FRAC_W);
			end
			egu_pkg::ACT_TANH: begin
				d = one - round_product(a, a, FRAC_W);
				na = ga + round_product(g, d, FRAC_W);
			end
			egu_pkg::ACT_XENT:
				if (it.second) na = ga + round_product(g, a - b, FRAC_W);
			egu_pkg::ACT_DROPOUT:
				if (a != 0)
					na = ga + (g * (longint'(1) << egu_pkg::REG_FRAC)) /
						((longint'(1) << egu_pkg::REG_FRAC) - longint'(dp_shadow));
			egu_pkg::ACT_SGD:
				na = a - round_product(longint'(lr_shadow), ga, egu_pkg::REG_FRAC);
			default: ;
		endcase
		r.na = clip32(na, flag);
		r.nb = clip32(nb, flag);
		r.sat = flag;
		return r;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
			1: return $urandom_range(1) ? 32'($urandom_range(65536 * 4)) :
				-32'($urandom_range(65536 * 4));
			2: return $urandom_range(1) ? 32'h0001_0000 : 32'h0;
			3: return 32'($signed($urandom_range(255)) - 128) <<< 12;
			default: return $urandom;
		endcase
	endfunction

	function automatic grad_item_t random_item();
		grad_item_t it;
		it.act = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
		it.second = $urandom_range(3) != 0;
		it.g = pick_value();
		it.a = pick_value();
		it.b = pick_value();
		it.ga = pick_value();
		it.gb = pick_value();
		return it;
	endfunction

	task automatic add_row(logic [3:0] act, logic second, logic [31:0] g, logic [31:0] a,
			logic [31:0] b, logic [31:0] ga, logic [31:0] gb,
			logic fixed = 1'b0, logic [31:0] na = '0, logic [31:0] nb = '0, logic sat = 1'b0);
		stim_row_t r;
		r.item = '{act, second, g, a, b, ga, gb};
		r.fixed = fixed;
		r.want = '{na, nb, sat};
		directed_rows.push_back(r);
	endtask

	task automatic send_item(grad_item_t it, logic fixed, grad_result_t want);
		forever begin
			@(negedge clk);
			if ($urandom_range(99) < snd_idle) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= {it.gb, it.ga, it.b, it.a, it.g};
				s_tuser <= {it.second, it.act};
				@(posedge clk);
				while (!s_tready) @(posedge clk);
				pending_grads.push_back(fixed ? want : compute_gradients(it));
				break;
			end
		end
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_LR)
			lr_shadow = value[egu_pkg::LR_W-1:0];
		else
			dp_shadow = value[egu_pkg::DP_W-1:0];
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_grads.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= rcv_idle);

	always @(posedge clk) begin
		grad_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[63:32], m_tuser[0]};
			if (pending_grads.size() == 0) begin
				$display("%0t unexpected transfer: got na=%h nb=%h sat=%b",
					$time, got.na, got.nb, got.sat);
				errors++;
			end else begin
				want = pending_grads.pop_front();
				if (got !== want) begin
					$display("%0t expected na=%h nb=%h sat=%b, got na=%h nb=%h sat=%b",
						$time, want.na, want.nb, want.sat, got.na, got.nb, got.sat);
					errors++;
				end
			end
		end
	end

	initial begin
		int lr_vals[RANDOM_PHASES] = '{0, 131071, 65536, 1, 655, 40000};
		int dp_vals[RANDOM_PHASES] = '{65535, 0, 32768, 65535, 12345, 1};
		grad_result_t none;
		none = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_row(egu_pkg::ACT_ADD, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0);
		add_row(egu_pkg::ACT_ADD, 1, 32'h7fffffff, 0, 0, 32'h7fffffff, 1,
			1, 32'h7fffffff, 32'h7fffffff, 1);
		add_row(egu_pkg::ACT_SUB, 1, 32'h80000000, 0, 0, 32'h80000000, 0,
			1, 32'h80000000, 32'h7fffffff, 1);
		add_row(egu_pkg::ACT_SUB, 0, 5, 0, 0, 7, 9, 1, 12, 9, 0);
		add_row(egu_pkg::ACT_MUL, 0, 32'h80000000, 32'h7fffffff, 3, 0, 0);
		add_row(egu_pkg::ACT_MUL, 1, 32'h7fffffff, 32'h80000000, 32'h80000000, 1, 2);
		add_row(egu_pkg::ACT_DIV, 1, 32'h00030000, 32'h80000000, 0, 0, 0);
		add_row(egu_pkg::ACT_DIV, 0, 32'h80000000, 5, 7, 0, 4);
		add_row(egu_pkg::ACT_DIV, 1, 32'h7fffffff, 32'h7fffffff, 32'hffffffff,
			32'h80000000, 0);
		add_row(egu_pkg::ACT_SQUARE, 1, 32'h80000000, 32'h80000000, 0, 0, 3);
		add_row(egu_pkg::ACT_RELU, 1, 100, 0, 0, 5, 6, 1, 5, 6, 0);
		add_row(egu_pkg::ACT_RELU, 1, 100, 1, 0, 5, 6, 1, 105, 6, 0);
		add_row(egu_pkg::ACT_SIGMOID, 1, 32'h7fffffff, 32'h80000000, 0, 0, 0);
		add_row(egu_pkg::ACT_TANH, 0, 32'h80000000, 32'h7fffffff, 0, 0, 0);
		add_row(egu_pkg::ACT_SOFTMAX, 1, 32'h00010000, 32'h00008000, 0, 0, 0);
		add_row(egu_pkg::ACT_XENT, 0, 32'h7fffffff, 3, 4, 8, 9, 1, 8, 9, 0);
		add_row(egu_pkg::ACT_XENT, 1, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0);
		add_row(egu_pkg::ACT_DROPOUT, 1, 77, 0, 0, 3, 4, 1, 3, 4, 0);
		add_row(egu_pkg::ACT_DROPOUT, 1, 32'h80000000, 1, 0, 0, 0);
		add_row(egu_pkg::ACT_SGD, 1, 0, 32'h7fffffff, 0, 32'h80000000, 1);
		add_row(ACT_UNUSED_LO, 1, 1, 2, 3, 32'h80000000, 32'h7fffffff,
			1, 32'h80000000, 32'h7fffffff, 0);
		add_row(ACT_UNUSED_HI, 0, 32'hffffffff, 0, 0, 11, 22, 1, 11, 22, 0);
		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			write_reg(ADDR_LR, {$urandom} << egu_pkg::LR_W | 32'(lr_vals[ph]));
			write_reg(ADDR_DP, {$urandom} << egu_pkg::DP_W | 32'(dp_vals[ph]));
			case (ph / 2)
				0: begin snd_idle = 32; rcv_idle = 62; end
				1: begin snd_idle = 62; rcv_idle = 32; end
				default: begin snd_idle = 0; rcv_idle = 0; end
			endcase
			repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, none);
		end

		drain();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
